// ===== sv/b64enc_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64enc_pkg;

    localparam int CMD_DEPTH_DEF = 2;
    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out;

    // One request worth of characters, slot 0 goes out first.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            eom;
    } t_cmd;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

// ===== sv/b64enc_front.sv =====
// Front end: accepts bytes, keeps leftover bits and phase, builds character commands.
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_item,
    input  logic i_full,
    output logic o_wr,
    output t_cmd o_cmd
);

    logic [3:0] r_bits, n_bits;
    logic [1:0] r_pairs, n_pairs;
    logic [1:0] r_phase, n_phase;

    logic [5:0] c0, c1, flush_grp;
    logic [3:0] rem_bits;
    logic [1:0] rem_pairs;
    logic [1:0] data_cnt;
    logic       has_flush;
    logic [1:0] k_cnt;
    logic [1:0] ph_k;
    logic [1:0] pads;
    logic [2:0] total;
    logic       eom;

    assign eom  = i_item.end_of_message;
    assign o_wr = i_push && !i_full;

    always_comb begin
        c1        = 6'd0;
        case (r_pairs)
            2'd0: begin
                c0        = i_item.data_byte[7:2];
                rem_bits  = {2'b00, i_item.data_byte[1:0]};
                rem_pairs = 2'd1;
                data_cnt  = 2'd1;
            end
            2'd1: begin
                c0        = {r_bits[1:0], i_item.data_byte[7:4]};
                rem_bits  = i_item.data_byte[3:0];
                rem_pairs = 2'd2;
                data_cnt  = 2'd1;
            end
            default: begin
                c0        = {r_bits[3:0], i_item.data_byte[7:6]};
                c1        = i_item.data_byte[5:0];
                rem_bits  = 4'd0;
                rem_pairs = 2'd0;
                data_cnt  = 2'd2;
            end
        endcase

        // zero-fill the remaining bits on the right
        flush_grp = (rem_pairs == 2'd1) ? {rem_bits[1:0], 4'b0000}
                                        : {rem_bits[3:0], 2'b00};
        has_flush = eom && (rem_pairs != 2'd0);
        k_cnt     = data_cnt + {1'b0, has_flush};
        ph_k      = r_phase + k_cnt;
        pads      = eom ? (2'd0 - ph_k) : 2'd0;
        total     = {1'b0, k_cnt} + {1'b0, pads};

        o_cmd.chars[0] = b64_char(c0);
        if (data_cnt == 2'd2) begin
            o_cmd.chars[1] = b64_char(c1);
        end else if (has_flush) begin
            o_cmd.chars[1] = b64_char(flush_grp);
        end else begin
            o_cmd.chars[1] = PAD_CHAR;
        end
        o_cmd.chars[2] = PAD_CHAR;
        o_cmd.chars[3] = PAD_CHAR;
        o_cmd.last_idx = 2'(total - 3'd1);
        o_cmd.eom      = eom;

        n_bits  = r_bits;
        n_pairs = r_pairs;
        n_phase = r_phase;
        if (o_wr) begin
            if (eom) begin
                n_bits  = 4'd0;
                n_pairs = 2'd0;
                n_phase = 2'd0;
            end else begin
                n_bits  = rem_bits;
                n_pairs = rem_pairs;
                n_phase = ph_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= 4'd0;
            r_pairs <= 2'd0;
            r_phase <= 2'd0;
        end else begin
            r_bits  <= n_bits;
            r_pairs <= n_pairs;
            r_phase <= n_phase;
        end
    end

    // phase and held pairs advance together within a message
    a_phase_tracks_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == r_pairs) else $error("phase out of step with leftover bits");

    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr && eom) |=> (r_phase == 2'd0 && r_pairs == 2'd0 && r_bits == 4'd0))
        else $error("state not cleared after message end");

endmodule

// ===== sv/b64enc_cmdq.sv =====
// Short command queue between the front end and the character serializer.
module b64enc_cmdq
    import b64enc_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = i_wr ? ptr_inc(r_wp) : r_wp;
        n_rp  = i_rd ? ptr_inc(r_rp) : r_rp;
        n_cnt = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full)) else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty)) else $error("command queue underflow");

endmodule

// ===== sv/b64enc_back.sv =====
// Back end: walks commands one char a cycle into the output reg unless held.
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_result
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_out       r_out, n_out;
    logic       load;
    logic       at_end;

    assign load     = !r_valid || i_pop;
    assign at_end   = (r_idx == i_cmd.last_idx);
    assign o_empty  = !r_valid;
    assign o_result = r_out;

    always_comb begin
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_out     = r_out;
        o_cmd_pop = 1'b0;
        if (load) begin
            n_valid = !i_cmd_empty;
            if (!i_cmd_empty) begin
                n_out.out_char  = i_cmd.chars[r_idx];
                n_out.last_char = i_cmd.eom && at_end;
                o_cmd_pop       = at_end;
                n_idx           = at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // a command being walked stays at the queue head until its last slot
    a_mid_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> !i_cmd_empty) else $error("command lost mid-walk");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_empty |-> (r_idx <= i_cmd.last_idx)) else $error("slot index past command");

endmodule

// ===== sv/base64_stream_encoder.sv =====
// Top level of the streaming base64 encoder (standard alphabet, '=' padded).
//
// Each request on the input queue carries one raw byte and a flag on the final
// byte of a message; each request on the output queue carries one ASCII
// character and a flag on the final character of the encoded message. A byte
// is accepted in any cycle in which push is high and full is low, so bytes may
// arrive back to back; full rises only when the command queue between the
// front end and the serializer (CMD_DEPTH entries) has no room. Each byte
// becomes one or two alphabet characters, and the final byte of a message also
// flushes the leftover bits as one zero-filled character and adds '=' until
// the message length is a multiple of four, so one byte yields one to four
// characters. The output side delivers one character per cycle while pop is
// held high, so the sustained rate is set by that single character port:
// in mid-message three bytes yield four characters. With the serializer
// idle, the first character of a byte passes through the command queue and
// then the output register. There is no configuration, and after reset the
// encoder is ready at once; after a flagged byte the next byte starts a fresh
// message.
module base64_stream_encoder
    import b64enc_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic cmd_wr;
    t_cmd cmd_in;
    t_cmd cmd_head;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;

    assign full = cmd_full;

    b64enc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_full  (cmd_full),
        .o_wr    (cmd_wr),
        .o_cmd   (cmd_in)
    );

    b64enc_cmdq #(
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_cmd   (cmd_head),
        .o_empty (cmd_empty)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the base64 stream encoder.
`timescale 1ns / 1ps

module testbench;
    import b64enc_pkg::*;

    // Quiet time with nothing accepted on either side before the run is declared hung.
    // The longest legal stretch is the forced receiver hold plus one idle burst.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int HOLD_AFTER_REQS = 30;
    localparam int QUIET_TAIL = 25;      // last requests run with no idling on either side
    localparam int RANDOM_REQS = 105;

    // Standard alphabet, index 0 in the top byte.
    localparam bit [8*64-1:0] B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_item;
    logic empty;
    logic pop;
    t_out o_result;

    base64_stream_encoder uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_item  = '0;
    end

    always #6 i_clk = ~i_clk;

    // Byte requests not yet accepted; the driver always offers the head.
    t_in  pending_bytes[$];
    // Characters the encoder owes us, oldest first.
    t_out expected_chars[$];

    // Encoder state as we track it: leftover bits (right aligned), how many
    // bit pairs of them are valid, and characters sent in this message mod 4.
    logic [3:0] held_bits  = '0;
    logic [1:0] held_pairs = '0;
    logic [1:0] sent_phase = '0;

    int error_count   = 0;
    int accepted_reqs = 0;

    function automatic logic [7:0] b64_symbol(input int unsigned v);
        return B64_SYMBOLS[8*(63 - v) +: 8];
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic eom);
        t_in req;
        req.data_byte      = b;
        req.end_of_message = eom;
        pending_bytes.insert(pending_bytes.size(), req);
    endfunction

    // Works out the one to four characters that one accepted byte produces
    // and appends them to the expected queue.
    function automatic void encode_byte(input t_in req);
        t_out        burst[4];
        int unsigned acc;
        int unsigned nbits;
        int          count;
        nbits = 2 * held_pairs;
        acc   = ((32'(held_bits) & ((32'd1 << nbits) - 1)) << 8) | 32'(req.data_byte);
        nbits = nbits + 8;
        count = 0;
        // Every complete 6-bit group goes out, most significant first.
        while (nbits >= 6) begin
            nbits = nbits - 6;
            burst[count].out_char  = b64_symbol((acc >> nbits) & 32'h3F);
            burst[count].last_char = 1'b0;
            count++;
            sent_phase++;
        end
        acc = acc & ((32'd1 << nbits) - 1);
        if (!req.end_of_message) begin
            held_bits  = acc[3:0];
            held_pairs = 2'(nbits / 2);
        end else begin
            // Flush leftovers zero-filled on the right, then pad to a quad.
            if (nbits > 0) begin
                burst[count].out_char  = b64_symbol((acc << (6 - nbits)) & 32'h3F);
                burst[count].last_char = 1'b0;
                count++;
                sent_phase++;
            end
            while (sent_phase != 2'd0) begin
                burst[count].out_char  = PAD_CHAR;
                burst[count].last_char = 1'b0;
                count++;
                sent_phase++;
            end
            burst[count - 1].last_char = 1'b1;
            held_bits  = '0;
            held_pairs = '0;
        end
        for (int k = 0; k < count; k++) begin
            expected_chars.insert(expected_chars.size(), burst[k]);
        end
    endfunction

    // Stimulus and end of run.
    initial begin
        int msg_len;
        int queued;
        logic [7:0] b;

        // Directed part: one-byte messages at the extremes (two pads each),
        // two-byte messages (one pad), full triplets with no pad, and longer
        // messages of four and five bytes (two pads and one pad).
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h4D, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h6E, 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'hFE, 1'b1);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hC3, 1'b1);

        // Random messages: mostly short, now and then a long unflagged run
        // that walks the leftover state round and round before it ends.
        queued = 0;
        while (queued < RANDOM_REQS) begin
            if ($urandom_range(0, 9) == 0) begin
                msg_len = $urandom_range(9, 24);
            end else begin
                msg_len = $urandom_range(1, 6);
            end
            for (int k = 0; k < msg_len; k++) begin
                case ($urandom_range(0, 9))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                add_byte(b, k == msg_len - 1);
            end
            queued += msg_len;
        end

        // Synchronous reset, released on a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: every request accepted and every character seen; the
        // watchdog covers a hang here.
        while (pending_bytes.size() != 0 || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        // Keep clocking after the drain so a stray extra character would be caught.
        repeat (8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Sender: offers the head of the pending queue on falling edges, with
    // random idle bursts except in the quiet tail of the run.
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (tx_gap == 0 && pending_bytes.size() >= QUIET_TAIL
                    && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(1, 11);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                push   <= 1'b1;
                i_item <= pending_bytes[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold once traffic is
    // flowing so the command queue fills and full has to push back.
    int rx_gap      = 0;
    int rx_hold     = 0;
    bit hold_issued = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (!hold_issued && accepted_reqs >= HOLD_AFTER_REQS) begin
                hold_issued = 1'b1;
                rx_hold     = RX_HOLD_CYCLES;
            end
            if (rx_gap == 0 && pending_bytes.size() >= QUIET_TAIL
                    && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(1, 11);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Monitor: rising-edge sampling of both handshakes. DUT outputs update
    // by nonblocking assignment, so the values read here are pre-edge.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (push && !full) begin
                encode_byte(i_item);
                void'(pending_bytes.pop_front());
                accepted_reqs++;
            end
            if (pop && !empty) begin
                if (expected_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected character: expected none, actual %h/%b",
                             $time, o_result.out_char, o_result.last_char);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_result.out_char !== want.out_char) begin
                        error_count++;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.out_char, o_result.out_char);
                    end
                    if (o_result.last_char !== want.last_char) begin
                        error_count++;
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.last_char, o_result.last_char);
                    end
                end
            end
        end
    end

    // Watchdog: cycles in which neither side moves a request.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/b64enc_pkg.sv
sv/b64enc_front.sv
sv/b64enc_cmdq.sv
sv/b64enc_back.sv
sv/base64_stream_encoder.sv
test/testbench.sv
